// ===== rtl/linear_probe_hash_insert_top_assert.svh =====
// Assertion macros used by the RTL top module.
`ifndef LINEAR_PROBE_HASH_INSERT_TOP_ASSERT_SVH
`define LINEAR_PROBE_HASH_INSERT_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define LPHI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define LPHI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/lphi_pkg.sv =====
package lphi_pkg;

	// Field widths of the item channels and the config register
	localparam int KEY_IN_W = 16;
	localparam int SLOT_W   = 5;
	localparam int STAT_W   = 2;
	localparam int OFS_W    = 16;

	// key + offset, one carry bit
	localparam int SUM_W  = 17;

	// Remainder steps: reciprocal multiply, then multiply back and subtract
	localparam int HASH_STEPS = 2;
	localparam int HCNT_W     = 1;

	// Defaults
	localparam int TABLE_SIZE_DEF = 17;
	localparam int KEY_WIDTH_DEF  = 16;
	localparam logic [OFS_W-1:0] HASH_OFFSET_RST = 16'd3;

	// Result status codes
	localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
	localparam logic [STAT_W-1:0] ST_OCCUPIED = 2'd3;

	// Item actions
	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_READ   = 1'b1;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_PROBE,
		S_RDREQ,
		S_RDCHK,
		S_DONE
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic ready;     // take an item
		logic clr;       // clearing pass write
		logic load;      // latch accepted item
		logic hash;      // one remainder step
		logic probe;     // read at probe pointer, advance
		logic rd_slot;   // read at requested slot
		logic res_ins;   // write key, latch insert result
		logic res_full;  // latch table-full result
		logic res_rd;    // latch read result
		logic out_load;  // move result to output register
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clr_last;
		logic hash_last;
		logic free_hit;
		logic probe_full;
		logic out_free;
	} sts_t;

endpackage

// ===== rtl/lphi_req_if.sv =====
interface lphi_req_if;
	import lphi_pkg::*;

	logic                valid;
	logic                ready;
	logic                action;
	logic [KEY_IN_W-1:0] key;
	logic [SLOT_W-1:0]   slot;

	modport source (output valid, action, key, slot, input ready);
	modport sink   (input valid, action, key, slot, output ready);
endinterface

// ===== rtl/lphi_rsp_if.sv =====
interface lphi_rsp_if;
	import lphi_pkg::*;

	logic                valid;
	logic                ready;
	logic [STAT_W-1:0]   status;
	logic [SLOT_W-1:0]   slot_used;
	logic [KEY_IN_W-1:0] key_out;

	modport source (output valid, status, slot_used, key_out, input ready);
	modport sink   (input valid, status, slot_used, key_out, output ready);
endinterface

// ===== rtl/lphi_ctrl.sv =====
module lphi_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_action,
	input  lphi_pkg::sts_t   sts,
	output lphi_pkg::cmd_t   cmd,
	output lphi_pkg::state_t st
);
	import lphi_pkg::*;

	state_t state_q, state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (sts.clr_last) state_nxt = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) state_nxt = (in_action == ACT_READ) ? S_RDREQ : S_HASH;
			end
			S_HASH: begin
				if (sts.hash_last) state_nxt = S_PROBE;
			end
			S_PROBE: begin
				if (sts.free_hit || sts.probe_full) state_nxt = S_DONE;
			end
			S_RDREQ: begin
				state_nxt = S_RDCHK;
			end
			S_RDCHK: begin
				state_nxt = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_CLEAR;
			end
		endcase
	end

	// Commands
	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
			end
			S_IDLE: begin
				cmd.ready = 1'b1;
				cmd.load  = in_valid;
			end
			S_HASH: begin
				cmd.hash = 1'b1;
			end
			S_PROBE: begin
				cmd.probe    = 1'b1;
				cmd.res_ins  = sts.free_hit;
				cmd.res_full = !sts.free_hit && sts.probe_full;
			end
			S_RDREQ: begin
				cmd.rd_slot = 1'b1;
			end
			S_RDCHK: begin
				cmd.res_rd = 1'b1;
			end
			S_DONE: begin
				cmd.out_load = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	assign st = state_q;

endmodule

// ===== rtl/lphi_dp.sv =====
module lphi_dp #(
	parameter int TABLE_SIZE = lphi_pkg::TABLE_SIZE_DEF,
	parameter int KEY_WIDTH  = lphi_pkg::KEY_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lphi_pkg::OFS_W-1:0]    cfg_wdata,
	input  logic [lphi_pkg::KEY_IN_W-1:0] in_key,
	input  logic [lphi_pkg::SLOT_W-1:0]   in_slot,
	input  lphi_pkg::cmd_t                cmd,
	output lphi_pkg::sts_t                sts,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [lphi_pkg::STAT_W-1:0]   out_status,
	output logic [lphi_pkg::SLOT_W-1:0]   out_slot_used,
	output logic [lphi_pkg::KEY_IN_W-1:0] out_key_out
);
	import lphi_pkg::*;

	localparam int IDX_W  = $clog2(TABLE_SIZE);
	localparam int KW_EFF = (KEY_WIDTH < KEY_IN_W) ? KEY_WIDTH : KEY_IN_W;
	localparam logic [KEY_IN_W-1:0] KEY_MASK =
		KEY_IN_W'((33'(1) << KW_EFF) - 33'(1));
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

	// Reciprocal of TABLE_SIZE, exact for every sum below 2**SUM_W
	localparam int     RCP_SH = SUM_W + IDX_W;
	localparam int     RCP_W  = SUM_W + 1;
	localparam int     PROD_W = SUM_W + RCP_W;
	localparam int     QUO_W  = PROD_W - RCP_SH;
	localparam longint RCP_M  =
		((longint'(1) << RCP_SH) + longint'(TABLE_SIZE) - longint'(1)) / longint'(TABLE_SIZE);
	localparam logic [RCP_W-1:0] RCP_K  = RCP_W'(RCP_M);
	localparam logic [SUM_W-1:0] TS_SUM = SUM_W'(TABLE_SIZE);

	// Config register
	logic [OFS_W-1:0] hash_offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_offset_q <= HASH_OFFSET_RST;
		end else if (cfg_we) begin
			hash_offset_q <= cfg_wdata;
		end
	end

	// Item registers
	logic [KEY_IN_W-1:0] key_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [SUM_W-1:0]    sum_q;
	logic [PROD_W-1:0]   prod_q;
	logic [IDX_W-1:0]    r_q;       // remainder, then probe pointer
	logic [HCNT_W-1:0]   hcnt_q;
	logic [IDX_W-1:0]    chk_cnt_q;
	logic [IDX_W-1:0]    clr_ptr_q;
	logic [KEY_IN_W-1:0] key_m;
	logic [QUO_W-1:0]    quo;
	logic [SUM_W-1:0]    rem_full;

	// Table memory: valid bit on top of the key
	logic [KEY_WIDTH:0]  mem [TABLE_SIZE];
	logic                rd_en;
	logic [IDX_W-1:0]    rd_addr;
	logic                slot_in_range;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;
	logic [KEY_WIDTH:0]  wr_data;
	logic [KEY_WIDTH:0]  rdata_s1;
	logic [IDX_W-1:0]    rd_ptr_s1;
	logic                rd_vld_s1;
	logic                entry_used;

	assign key_m    = in_key & KEY_MASK;
	assign quo      = prod_q[PROD_W-1:RCP_SH];
	assign rem_full = sum_q - SUM_W'(quo) * TS_SUM;

	// Remainder of key + offset: quotient by reciprocal, then subtract; then probing
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q  <= key_m;
			slot_q <= in_slot;
			sum_q  <= SUM_W'(key_m) + SUM_W'(hash_offset_q);
			r_q    <= '0;
		end else if (cmd.hash) begin
			if (hcnt_q == '0) begin
				prod_q <= PROD_W'(sum_q) * PROD_W'(RCP_K);
			end else begin
				r_q <= IDX_W'(rem_full);
			end
		end else if (cmd.probe) begin
			r_q <= (r_q == LAST_IDX) ? '0 : r_q + 1'b1;
		end
	end

	// Step counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hcnt_q    <= '0;
			chk_cnt_q <= '0;
			clr_ptr_q <= '0;
		end else begin
			if (cmd.load) begin
				hcnt_q    <= '0;
				chk_cnt_q <= '0;
			end else begin
				if (cmd.hash) hcnt_q <= hcnt_q + 1'b1;
				if (cmd.probe && rd_vld_s1) chk_cnt_q <= chk_cnt_q + 1'b1;
			end
			if (cmd.clr) clr_ptr_q <= clr_ptr_q + 1'b1;
		end
	end

	// Memory port control
	assign slot_in_range = 32'(slot_q) < 32'(TABLE_SIZE);
	assign rd_en   = cmd.probe || (cmd.rd_slot && slot_in_range);
	assign rd_addr = cmd.probe ? r_q : IDX_W'(slot_q);
	assign wr_en   = cmd.clr || cmd.res_ins;
	assign wr_addr = cmd.clr ? clr_ptr_q : rd_ptr_s1;
	assign wr_data = cmd.clr ? '0 : {1'b1, KEY_WIDTH'(key_q)};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1  <= mem[rd_addr];
			rd_ptr_s1 <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
		end
	end

	assign entry_used = rdata_s1[KEY_WIDTH];

	// Status to controller
	always_comb begin
		sts            = '0;
		sts.clr_last   = clr_ptr_q == LAST_IDX;
		sts.hash_last  = hcnt_q == HCNT_W'(HASH_STEPS - 1);
		sts.free_hit   = rd_vld_s1 && !entry_used;
		sts.probe_full = rd_vld_s1 && entry_used && (chk_cnt_q == LAST_IDX);
		sts.out_free   = !out_valid || out_ready;
	end

	// Result hold
	logic [STAT_W-1:0]   res_status_q;
	logic [SLOT_W-1:0]   res_slot_q;
	logic [KEY_IN_W-1:0] res_key_q;

	always_ff @(posedge clk) begin
		if (cmd.res_ins) begin
			res_status_q <= ST_INSERTED;
			res_slot_q   <= SLOT_W'(rd_ptr_s1);
			res_key_q    <= '0;
		end else if (cmd.res_full) begin
			res_status_q <= ST_FULL;
			res_slot_q   <= '0;
			res_key_q    <= '0;
		end else if (cmd.res_rd) begin
			res_slot_q <= slot_q;
			if (rd_vld_s1 && entry_used) begin
				res_status_q <= ST_OCCUPIED;
				res_key_q    <= KEY_IN_W'(rdata_s1[KEY_WIDTH-1:0]);
			end else begin
				res_status_q <= ST_EMPTY;
				res_key_q    <= '0;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status    <= res_status_q;
			out_slot_used <= res_slot_q;
			out_key_out   <= res_key_q;
		end
	end

endmodule

// ===== rtl/linear_probe_hash_insert_top.sv =====
// Open-addressing hash table with linear probing.
// req channel (valid/ready): action 0 inserts key at the first free slot at or
// after (key + hash_offset) mod TABLE_SIZE, wrapping; action 1 reads a slot.
// rsp channel (valid/ready): one result item per request item: status,
// slot_used and key_out. A full table gives status table-full, nothing written.
// cfg_we/cfg_wdata write hash_offset in any cycle the block is idle.
// Sequence: an insert computes the remainder (reciprocal multiply, then
// multiply back and subtract), then probes with one registered table read
// per cycle, one slot checked per cycle after the first, then loads the
// output register, which raises rsp.valid. A read does a registered table
// read of the requested slot, checks it, then loads the output register.
// One item is in work at a time; req.ready is high only while idle, from the
// cycle after the previous result is loaded. The output register lets the
// next item be accepted while a result waits; while rsp is stalled a finished
// item holds in the block.
// Reset: the table's valid bits are swept clear, one slot per cycle, after
// reset; req.ready stays low during that pass.
// hash_offset resets to 3.
module linear_probe_hash_insert_top #(
	parameter int TABLE_SIZE = lphi_pkg::TABLE_SIZE_DEF,
	parameter int KEY_WIDTH  = lphi_pkg::KEY_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [lphi_pkg::OFS_W-1:0] cfg_wdata,
	lphi_req_if.sink                   req,
	lphi_rsp_if.source                 rsp
);
	import lphi_pkg::*;

	`include "linear_probe_hash_insert_top_assert.svh"

	cmd_t   cmd;
	sts_t   sts;
	state_t st;
	logic   req_acc;
	logic   rsp_no_key;

	lphi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_action (req.action),
		.sts       (sts),
		.cmd       (cmd),
		.st        (st)
	);

	lphi_dp #(
		.TABLE_SIZE (TABLE_SIZE),
		.KEY_WIDTH  (KEY_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_key        (req.key),
		.in_slot       (req.slot),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (rsp.valid),
		.out_ready     (rsp.ready),
		.out_status    (rsp.status),
		.out_slot_used (rsp.slot_used),
		.out_key_out   (rsp.key_out)
	);

	assign req.ready = cmd.ready;

	// Terms for the checks below
	assign req_acc    = req.valid && req.ready;
	assign rsp_no_key = rsp.valid && (rsp.status == ST_INSERTED || rsp.status == ST_FULL);

	// An accepted item always starts work
	`LPHI_ASSERT_NXT(a_accept_starts, clk, arst_n, req_acc, st != S_IDLE, "item did not start")

	// A new result appears only when the controller finishes an item
	`LPHI_ASSERT_IMP(a_rsp_done, clk, arst_n, $rose(rsp.valid), $past(st) == S_DONE, "stray item")

	// Inserts report no key
	`LPHI_ASSERT_IMP(a_ins_no_key, clk, arst_n, rsp_no_key, rsp.key_out == '0, "key on insert")

endmodule
